// ----- src/rpp_pkg.sv -----
// ----------------------------------------------------------------------------
// rpp_pkg
// shared constants and table generator for the point rotation pipeline
// ----------------------------------------------------------------------------
package rpp_pkg;

  localparam int DegreesPerTurn    = 360;
  localparam int TableEntries      = 361;
  localparam int TableFractionBits = 16;
  localparam int TableIdxW         = $clog2(TableEntries);
  localparam int Stages            = 7;

  // 180/pi in Q24
  localparam logic [29:0] DegPerRadQ24 = 30'd961263669;
  // floor(2^32 / 360), quotient may come out one low
  localparam logic [23:0] Recip360 = 24'd11930464;
  // makes the turn count non-negative before the reduction
  localparam logic [22:0] TurnBias = 23'd2949120;

  localparam longint PiQ30  = 64'sd3373259426;
  localparam longint Q30One = 64'sd1073741824;

  // taylor term divisors (2k)(2k+1) for sine and (2k-1)(2k) for cosine
  localparam longint SinDiv [10] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
                                     64'sd156, 64'sd210, 64'sd272, 64'sd342, 64'sd420};
  localparam longint CosDiv [10] = '{64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90,
                                     64'sd132, 64'sd182, 64'sd240, 64'sd306, 64'sd380};

  // sin (is_cos = 0) or cos (is_cos = 1) of angle x (Q30) mapped by quadrant, Q1.frac
  function automatic longint trig_entry(longint x, int quad, bit is_cos, int frac);
    longint x2, ts, ss, tc, sc, so, co, v;
    int     sh;
    x2 = (x * x) >>> 30;
    ts = x;
    ss = x;
    tc = Q30One;
    sc = Q30One;
    for (int k = 1; k <= 10; k++) begin
      ts = ((ts * x2) >>> 30) / SinDiv[k-1];
      tc = ((tc * x2) >>> 30) / CosDiv[k-1];
      if ((k & 1) == 1) begin
        ss = ss - ts;
        sc = sc - tc;
      end else begin
        ss = ss + ts;
        sc = sc + tc;
      end
    end
    case (quad)
      0: begin so = ss;  co = sc;  end
      1: begin so = sc;  co = -ss; end
      2: begin so = -ss; co = -sc; end
      default: begin so = -sc; co = ss; end
    endcase
    v  = is_cos ? co : so;
    sh = 30 - frac;
    if (sh != 0) begin
      v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    end
    return v;
  endfunction

endpackage

// ----- src/rpp_angle.sv -----
// ----------------------------------------------------------------------------
// rpp_angle
// radians to degrees, reduction into one turn, and table lookup (3 stages)
// ----------------------------------------------------------------------------
module rpp_angle #(
  parameter int TableFractionBits = rpp_pkg::TableFractionBits,
  localparam int TW = TableFractionBits + 2
) (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  logic signed [31:0]   angle_i,
  output logic signed [TW-1:0] sin0_o,
  output logic signed [TW-1:0] sin1_o,
  output logic signed [TW-1:0] cos0_o,
  output logic signed [TW-1:0] cos1_o,
  output logic [15:0]          frac_o
);

  localparam int IW = rpp_pkg::TableIdxW;

  logic signed [TW-1:0] sin_tab [rpp_pkg::TableEntries];
  logic signed [TW-1:0] cos_tab [rpp_pkg::TableEntries];

  for (genvar d = 0; d < rpp_pkg::TableEntries; d++) begin : g_tab
    localparam int     Quad   = (d / 90) % 4;
    localparam longint AngQ30 = (longint'(d % 90) * rpp_pkg::PiQ30 + 64'sd90) / 64'sd180;
    localparam longint SinV = rpp_pkg::trig_entry(AngQ30, Quad, 1'b0, TableFractionBits);
    localparam longint CosV = rpp_pkg::trig_entry(AngQ30, Quad, 1'b1, TableFractionBits);
    assign sin_tab[d] = SinV[TW-1:0];
    assign cos_tab[d] = CosV[TW-1:0];
  end

  // stage 0: degrees in Q40
  logic signed [61:0] deg_d, deg_q;
  logic signed [62:0] deg_full;
  assign deg_full = angle_i * $signed({1'b0, rpp_pkg::DegPerRadQ24});
  assign deg_d    = deg_full[61:0];

  // stage 1: whole turns via reciprocal
  logic [22:0] turns;
  logic [46:0] qprod;
  logic [22:0] turns_q;
  logic [14:0] quot_q;
  logic [15:0] frac_s1_q;
  assign turns = {deg_q[61], deg_q[61:40]} + rpp_pkg::TurnBias;
  assign qprod = turns * rpp_pkg::Recip360;

  // stage 2: remainder and lookup
  logic [22:0]   rem_full;
  logic [9:0]    rem;
  logic [IW-1:0] idx0, idx1;
  assign rem_full = turns_q - 23'(quot_q) * 23'd360;
  assign rem      = (rem_full[9:0] >= 10'd360) ? rem_full[9:0] - 10'd360 : rem_full[9:0];
  assign idx0     = IW'(rem);
  assign idx1     = idx0 + IW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      deg_q <= deg_d;
    end
    if (en_i[1]) begin
      turns_q   <= turns;
      quot_q    <= qprod[46:32];
      frac_s1_q <= deg_q[39:24];
    end
    if (en_i[2]) begin
      sin0_o <= sin_tab[idx0];
      sin1_o <= sin_tab[idx1];
      cos0_o <= cos_tab[idx0];
      cos1_o <= cos_tab[idx1];
      frac_o <= frac_s1_q;
    end
  end

endmodule

// ----- src/rpp_interp.sv -----
// ----------------------------------------------------------------------------
// rpp_interp
// linear interpolation between floor and next degree (2 stages)
// ----------------------------------------------------------------------------
module rpp_interp #(
  parameter int TableFractionBits = rpp_pkg::TableFractionBits,
  localparam int TW = TableFractionBits + 2
) (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  logic signed [TW-1:0] sin0_i,
  input  logic signed [TW-1:0] sin1_i,
  input  logic signed [TW-1:0] cos0_i,
  input  logic signed [TW-1:0] cos1_i,
  input  logic [15:0]          frac_i,
  output logic signed [TW-1:0] sin_o,
  output logic signed [TW-1:0] cos_o
);

  localparam int PW = TW + 18;

  logic signed [17:0] w0, w1;
  assign w0 = $signed(18'h10000 - {2'b00, frac_i});
  assign w1 = $signed({2'b00, frac_i});

  logic signed [PW-1:0] sa_q, sb_q, ca_q, cb_q;
  logic signed [PW:0]   ssum, csum;
  logic signed [PW:0]   ssh, csh;

  assign ssum = PW'(sa_q) + PW'(sb_q) + (PW+1)'(32768);
  assign csum = PW'(ca_q) + PW'(cb_q) + (PW+1)'(32768);
  assign ssh  = ssum >>> 16;
  assign csh  = csum >>> 16;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sa_q <= PW'(sin0_i) * PW'(w0);
      sb_q <= PW'(sin1_i) * PW'(w1);
      ca_q <= PW'(cos0_i) * PW'(w0);
      cb_q <= PW'(cos1_i) * PW'(w1);
    end
    if (en_i[1]) begin
      sin_o <= ssh[TW-1:0];
      cos_o <= csh[TW-1:0];
    end
  end

endmodule

// ----- src/rpp_rotate.sv -----
// ----------------------------------------------------------------------------
// rpp_rotate
// rotation products, rounding, pivot add and saturation (2 stages)
// ----------------------------------------------------------------------------
module rpp_rotate #(
  parameter int TableFractionBits = rpp_pkg::TableFractionBits,
  localparam int TW = TableFractionBits + 2
) (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  logic signed [32:0]   dx_i,
  input  logic signed [32:0]   dy_i,
  input  logic signed [31:0]   pivot_x_i,
  input  logic signed [31:0]   pivot_y_i,
  input  logic signed [TW-1:0] sin_i,
  input  logic signed [TW-1:0] cos_i,
  output logic signed [31:0]   rotated_x_o,
  output logic signed [31:0]   rotated_y_o
);

  localparam int MW = 33 + TW;
  localparam int SW = MW + 1;

  logic signed [MW-1:0] xc_q, ys_q, xs_q, yc_q;
  logic signed [31:0]   px_q, py_q;

  logic signed [SW-1:0] half, sx, sy, vx, vy;
  assign half = SW'(1) <<< (TableFractionBits - 1);
  assign sx   = SW'(xc_q) - SW'(ys_q) + half;
  assign sy   = SW'(xs_q) + SW'(yc_q) + half;
  assign vx   = (sx >>> TableFractionBits) + SW'(px_q);
  assign vy   = (sy >>> TableFractionBits) + SW'(py_q);

  function automatic logic signed [31:0] sat32(logic signed [SW-1:0] v);
    if (v > SW'(64'sd2147483647)) begin
      return 32'h7fffffff;
    end else if (v < SW'(-64'sd2147483648)) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xc_q <= dx_i * cos_i;
      ys_q <= dy_i * sin_i;
      xs_q <= dx_i * sin_i;
      yc_q <= dy_i * cos_i;
      px_q <= pivot_x_i;
      py_q <= pivot_y_i;
    end
    if (en_i[1]) begin
      rotated_x_o <= sat32(vx);
      rotated_y_o <= sat32(vy);
    end
  end

endmodule

// ----- src/rotate_point_about_pivot.sv -----
// an accepted item passes the angle, interpolation and rotation stages in order; an output stall holds it
// throughput: one item per cycle while out_stall_i is low; every stage holds one item with its own valid bit
// a stage advances whenever it is empty or the stage after it advances
// rst_ni clears the valid bits only; sine and cosine tables are constant logic
// ----------------------------------------------------------------------------
// rotate_point_about_pivot
// rotates a Q16.16 point about a pivot by an angle in radians
// ----------------------------------------------------------------------------
module rotate_point_about_pivot #(
  parameter int TableFractionBits = rpp_pkg::TableFractionBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] pivot_x_i,
  input  logic signed [31:0] pivot_y_i,
  input  logic signed [31:0] angle_rad_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] rotated_x_o,
  output logic signed [31:0] rotated_y_o
);

  localparam int N  = rpp_pkg::Stages;
  localparam int TW = TableFractionBits + 2;

  logic [N-1:0] valid_q;
  logic [N:0]   en;

  always_comb begin
    en[N] = !out_stall_i;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // offsets and pivots ride along until the rotation stage
  logic signed [32:0] dx_q [5];
  logic signed [32:0] dy_q [5];
  logic signed [31:0] px_q [5];
  logic signed [31:0] py_q [5];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q[0] <= 33'(point_x_i) - 33'(pivot_x_i);
      dy_q[0] <= 33'(point_y_i) - 33'(pivot_y_i);
      px_q[0] <= pivot_x_i;
      py_q[0] <= pivot_y_i;
    end
    for (int k = 1; k < 5; k++) begin
      if (en[k]) begin
        dx_q[k] <= dx_q[k-1];
        dy_q[k] <= dy_q[k-1];
        px_q[k] <= px_q[k-1];
        py_q[k] <= py_q[k-1];
      end
    end
  end

  logic signed [TW-1:0] sin0, sin1, cos0, cos1, sin_v, cos_v;
  logic [15:0]          frac;

  rpp_angle #(.TableFractionBits(TableFractionBits)) u_angle (
    .clk_i   (clk_i),
    .en_i    (en[2:0]),
    .angle_i (angle_rad_i),
    .sin0_o  (sin0),
    .sin1_o  (sin1),
    .cos0_o  (cos0),
    .cos1_o  (cos1),
    .frac_o  (frac)
  );

  rpp_interp #(.TableFractionBits(TableFractionBits)) u_interp (
    .clk_i  (clk_i),
    .en_i   (en[4:3]),
    .sin0_i (sin0),
    .sin1_i (sin1),
    .cos0_i (cos0),
    .cos1_i (cos1),
    .frac_i (frac),
    .sin_o  (sin_v),
    .cos_o  (cos_v)
  );

  rpp_rotate #(.TableFractionBits(TableFractionBits)) u_rotate (
    .clk_i       (clk_i),
    .en_i        (en[6:5]),
    .dx_i        (dx_q[4]),
    .dy_i        (dy_q[4]),
    .pivot_x_i   (px_q[4]),
    .pivot_y_i   (py_q[4]),
    .sin_i       (sin_v),
    .cos_i       (cos_v),
    .rotated_x_o (rotated_x_o),
    .rotated_y_o (rotated_y_o)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && $countones(valid_q) == N))
    else $error("input stalled while pipeline has room");

  a_full_and_blocked_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(valid_q) == N && out_stall_i) |-> in_stall_o)
    else $error("input taken while pipeline is full and blocked");

  a_no_stall_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_stall_i && !in_valid_i && !valid_q[N-2]) |=> !out_valid_o)
    else $error("result appeared from an empty stage");
`endif

endmodule
